/* hdl/pdpf_pkg.sv */
// pdpf_pkg: shared types, packet constants and header table for the packet framer
// depends on: nothing
`timescale 1ns / 1ps

package pdpf_pkg;

  localparam int TILES_PER_PACKET = 40;
  localparam int BYTES_PER_TILE   = 16;

  localparam int RAW_SIZE = TILES_PER_PACKET * BYTES_PER_TILE;
  // a packet of fewer than two bytes would need a header and a trailer in one run
  localparam int PKT_SIZE = (RAW_SIZE < 2) ? 2 : RAW_SIZE;

  localparam int POS_W  = 10;
  localparam int SIZE_W = POS_W + 1;
  localparam int SUM_W  = 16;

  localparam logic [SIZE_W-1:0] PKT_SIZE_V = SIZE_W'(PKT_SIZE);
  localparam logic [7:0] LEN_LO = 8'(PKT_SIZE % 256);
  localparam logic [7:0] LEN_HI = 8'(PKT_SIZE / 256);

  localparam logic [7:0] HDR_SYNC0 = 8'h88;
  localparam logic [7:0] HDR_SYNC1 = 8'h33;
  localparam logic [7:0] HDR_CMD   = 8'h04;
  localparam logic [7:0] HDR_COMP  = 8'h00;
  localparam logic [7:0] PAD_BYTE  = 8'h00;

  // command + compression + length bytes
  localparam logic [SUM_W-1:0] SUM_INIT =
    SUM_W'(32'h04 + 32'h00 + (PKT_SIZE % 256) + (PKT_SIZE / 256));

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef logic [3:0] step_t;

  localparam step_t STEP_HDR_FIRST = 4'd0;
  localparam step_t STEP_HDR_LAST  = 4'd5;
  localparam step_t STEP_DATA      = 4'd6;
  localparam step_t STEP_SUM_LO    = 4'd7;
  localparam step_t STEP_SUM_HI    = 4'd8;
  localparam step_t STEP_PAD0      = 4'd9;
  localparam step_t STEP_PAD1      = 4'd10;

  // one classified input byte, as handed from front to back
  typedef struct packed {
    logic [7:0]       data;
    logic             hdr;
    logic             closes;
    logic [SUM_W-1:0] sum;
  } job_t;

  function automatic logic [7:0] header_byte(step_t idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = HDR_SYNC0;
      4'd1:    b = HDR_SYNC1;
      4'd2:    b = HDR_CMD;
      4'd3:    b = HDR_COMP;
      4'd4:    b = LEN_LO;
      4'd5:    b = LEN_HI;
      default: b = PAD_BYTE;
    endcase
    return b;
  endfunction

endpackage

/* hdl/pdpf_front.sv */
// pdpf_front: tracks packet position and checksum, classifies each input byte
// depends on: pdpf_pkg
`timescale 1ns / 1ps

module pdpf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                queue_full,
  input  logic [7:0]          data_byte,
  input  logic                restart,
  output logic                job_wr,
  output pdpf_pkg::job_t      job
);

  logic [pdpf_pkg::POS_W-1:0]  pos;
  logic [pdpf_pkg::SUM_W-1:0]  sum;
  logic [pdpf_pkg::POS_W-1:0]  pos_eff;
  logic [pdpf_pkg::SIZE_W-1:0] pos_inc;
  logic                        first;
  logic                        closes;
  logic [pdpf_pkg::SUM_W-1:0]  sum_base;
  logic [pdpf_pkg::SUM_W-1:0]  sum_next;
  logic [pdpf_pkg::POS_W-1:0]  pos_next;

  assign job_wr   = push && !queue_full;
  assign pos_eff  = restart ? '0 : pos;
  assign first    = (pos_eff == '0);
  assign pos_inc  = {1'b0, pos_eff} + pdpf_pkg::SIZE_W'(1);
  assign closes   = (pos_inc >= pdpf_pkg::PKT_SIZE_V);
  assign sum_base = first ? pdpf_pkg::SUM_INIT : sum;
  assign sum_next = sum_base + {8'h00, data_byte};
  assign pos_next = pos_inc[pdpf_pkg::POS_W-1:0];

  assign job.data   = data_byte;
  assign job.hdr    = first;
  assign job.closes = closes;
  assign job.sum    = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      sum <= '0;
    end else if (job_wr) begin
      if (closes) begin
        pos <= '0;
        sum <= '0;
      end else begin
        pos <= pos_next;
        sum <= sum_next;
      end
    end
  end

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    job_wr && closes |=> pos == '0 && sum == '0)
    else $error("packet close did not clear position and checksum");

endmodule

/* hdl/pdpf_queue.sv */
// pdpf_queue: short job queue between front and back, head visible without a read cycle
// depends on: pdpf_pkg
`timescale 1ns / 1ps

module pdpf_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  pdpf_pkg::job_t      wr_job,
  output logic                full,
  input  logic                rd_en,
  output logic                head_valid,
  output pdpf_pkg::job_t      head_job
);

  pdpf_pkg::job_t                mem [pdpf_pkg::QUEUE_DEPTH];
  logic [pdpf_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [pdpf_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [pdpf_pkg::QUEUE_AW:0]   count;

  assign full       = (count == (pdpf_pkg::QUEUE_AW+1)'(pdpf_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (pdpf_pkg::QUEUE_AW+1)'(pdpf_pkg::QUEUE_DEPTH))
    else $error("job queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> head_valid)
    else $error("job queue read while empty");

endmodule

/* hdl/pdpf_back.sv */
// pdpf_back: expands queued jobs into header, data and trailer beats into an output register
// depends on: pdpf_pkg
`timescale 1ns / 1ps

module pdpf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  pdpf_pkg::job_t      head_job,
  output logic                head_pop,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          tx_byte,
  output logic                last_of_run,
  output logic                packet_done
);

  logic                  out_valid;
  logic                  started;
  pdpf_pkg::step_t       step;
  pdpf_pkg::step_t       cur_step;
  pdpf_pkg::step_t       last_step;
  logic [7:0]            beat;
  logic                  beat_last;
  logic                  advance;
  logic                  out_taken;

  // a job that has not begun opens at its header or straight at its data byte
  assign cur_step  = started ? step
                   : (head_job.hdr ? pdpf_pkg::STEP_HDR_FIRST : pdpf_pkg::STEP_DATA);
  assign last_step = head_job.closes ? pdpf_pkg::STEP_PAD1 : pdpf_pkg::STEP_DATA;
  assign beat_last = (cur_step == last_step);

  always_comb begin
    unique case (cur_step) inside
      [pdpf_pkg::STEP_HDR_FIRST:pdpf_pkg::STEP_HDR_LAST]:
        beat = pdpf_pkg::header_byte(cur_step);
      pdpf_pkg::STEP_DATA:   beat = head_job.data;
      pdpf_pkg::STEP_SUM_LO: beat = head_job.sum[7:0];
      pdpf_pkg::STEP_SUM_HI: beat = head_job.sum[15:8];
      pdpf_pkg::STEP_PAD0, pdpf_pkg::STEP_PAD1:
        beat = pdpf_pkg::PAD_BYTE;
      default: beat = pdpf_pkg::PAD_BYTE;
    endcase
  end

  assign empty     = !out_valid;
  assign out_taken = pop && out_valid;
  assign advance   = head_valid && (!out_valid || out_taken);
  assign head_pop  = advance && beat_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      started   <= 1'b0;
      step      <= pdpf_pkg::STEP_HDR_FIRST;
    end else begin
      if (advance) begin
        out_valid   <= 1'b1;
        tx_byte     <= beat;
        last_of_run <= beat_last;
        packet_done <= head_job.closes;
        if (beat_last) begin
          started <= 1'b0;
        end else begin
          started <= 1'b1;
          step    <= cur_step + 4'd1;
        end
      end else if (out_taken) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_run_holds_head: assert property (@(posedge clk) disable iff (rst)
    started |-> head_valid)
    else $error("run in progress lost its job");

  a_plain_run_in_trailer: assert property (@(posedge clk) disable iff (rst)
    started && !head_job.hdr |-> step > pdpf_pkg::STEP_DATA && head_job.closes)
    else $error("headerless job resumed outside its trailer");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    started |-> step <= pdpf_pkg::STEP_PAD1 && step != pdpf_pkg::STEP_HDR_FIRST)
    else $error("sequencer step out of range");

endmodule

/* hdl/printer_data_packet_framer_core.sv */
// printer_data_packet_framer_core: top level of the printer data packet framer
// depends on: pdpf_pkg, pdpf_front, pdpf_queue, pdpf_back
`timescale 1ns / 1ps

// Wraps a stream of image data bytes into printer data packets of 640 bytes
// (40 tiles of 16 bytes). The first byte of a packet, or any byte pushed with
// restart high, is preceded by the header 88 33 04 00 80 02; the byte that
// completes a packet is followed by the checksum low byte, high byte, 00, 00.
// The checksum starts at 0x0086 and adds each data byte modulo 65536. A
// restart in mid packet drops the open packet without a trailer. Every beat
// of a run carries packet_done when the run closes a packet, and last_of_run
// marks the final beat that one input byte causes. Both sides behave as a
// queue: push while full is low, pop while empty is low. While pop stays high,
// data bytes stream at one beat per cycle; a header adds six beats and a
// trailer four, all issued by the output sequencer at one beat per cycle,
// while a four-entry job queue keeps the input side taking bytes meanwhile.
// The first beat of a run passes through the job queue and then the output
// register before it shows on tx_byte.

module printer_data_packet_framer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       restart,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] tx_byte,
  output logic       last_of_run,
  output logic       packet_done
);

  // classified byte heading into the job queue
  logic           job_wr;
  pdpf_pkg::job_t job;

  // oldest queued job, consumed once its last beat is issued
  logic           head_valid;
  logic           head_pop;
  pdpf_pkg::job_t head_job;

  // front: packet position and running checksum, decides header and trailer
  pdpf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .queue_full (full),
    .data_byte  (data_byte),
    .restart    (restart),
    .job_wr     (job_wr),
    .job        (job)
  );

  // queue between front and back so each side stalls on its own
  pdpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (job_wr),
    .wr_job     (job),
    .full       (full),
    .rd_en      (head_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back: beat sequencer feeding the output register
  pdpf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .head_pop    (head_pop),
    .empty       (empty),
    .pop         (pop),
    .tx_byte     (tx_byte),
    .last_of_run (last_of_run),
    .packet_done (packet_done)
  );

endmodule

/* tb/sv/tb_printer_data_packet_framer_core.sv */
// tb_printer_data_packet_framer_core: self-checking bench for the printer data packet framer
// depends on: pdpf_pkg (packet size and header sync bytes), printer_data_packet_framer_core
`timescale 1ns / 1ps

module tb_printer_data_packet_framer_core;

  // one pending input byte and one predicted link beat
  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } image_byte_t;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
    logic       done;
  } link_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] data_byte = 8'h00;
  logic       restart = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] tx_byte;
  logic       last_of_run;
  logic       packet_done;

  printer_data_packet_framer_core dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .restart     (restart),
    .empty       (empty),
    .pop         (pop),
    .tx_byte     (tx_byte),
    .last_of_run (last_of_run),
    .packet_done (packet_done)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // stimulus waiting for the driver, and link beats waiting for the dut
  image_byte_t pending_bytes[$];
  link_beat_t  expected_beats[$];

  int queued_count   = 0;
  int accepted_count = 0;
  int mismatch_count = 0;
  int send_idle_pct  = 14;
  int recv_idle_pct  = 59;

  // set on the rising edge that takes an input beat, cleared by the driver
  logic item_taken = 1'b0;

  // predictor state: data bytes already framed in the open packet and its checksum
  logic [9:0]  pkt_pos = '0;
  logic [15:0] pkt_sum = '0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 100)
      $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // frame one image byte: optional header, the byte, optional trailer
  task automatic predict_packet_beats(input logic [7:0] d, input logic rs);
    logic [7:0] hdr_bytes [6];
    logic [7:0] len_lo;
    logic [7:0] len_hi;
    logic       closes;
    len_lo = 8'(pdpf_pkg::PKT_SIZE % 256);
    len_hi = 8'(pdpf_pkg::PKT_SIZE / 256);
    hdr_bytes[0] = pdpf_pkg::HDR_SYNC0;
    hdr_bytes[1] = pdpf_pkg::HDR_SYNC1;
    hdr_bytes[2] = 8'h04;
    hdr_bytes[3] = 8'h00;
    hdr_bytes[4] = len_lo;
    hdr_bytes[5] = len_hi;
    // restart drops the open packet, no trailer for it
    if (rs) pkt_pos = '0;
    closes = (int'(pkt_pos) + 1 >= pdpf_pkg::PKT_SIZE);
    if (pkt_pos == '0) begin
      for (int i = 0; i < 6; i++) expected_beats.push_back('{hdr_bytes[i], 1'b0, closes});
      // checksum covers command, compression and length bytes
      pkt_sum = 16'h0004 + 16'(len_lo) + 16'(len_hi);
    end
    pkt_sum = pkt_sum + 16'(d);
    expected_beats.push_back('{d, !closes, closes});
    pkt_pos = pkt_pos + 10'd1;
    if (closes) begin
      expected_beats.push_back('{pkt_sum[7:0], 1'b0, 1'b1});
      expected_beats.push_back('{pkt_sum[15:8], 1'b0, 1'b1});
      expected_beats.push_back('{8'h00, 1'b0, 1'b1});
      expected_beats.push_back('{8'h00, 1'b1, 1'b1});
      pkt_pos = '0;
      pkt_sum = '0;
    end
  endtask

  // input side: take the beat and predict what it causes
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      predict_packet_beats(data_byte, restart);
      accepted_count++;
      item_taken = 1'b1;
    end
  end

  // output side: compare every popped beat with the oldest prediction
  always @(posedge clk) begin
    link_beat_t want;
    if (!rst && pop && !empty) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat tx_byte", tx_byte, 0);
      end else begin
        want = expected_beats.pop_front();
        if (tx_byte !== want.tx) report_mismatch("tx_byte", tx_byte, want.tx);
        if (last_of_run !== want.last) report_mismatch("last_of_run", last_of_run, want.last);
        if (packet_done !== want.done) report_mismatch("packet_done", packet_done, want.done);
      end
    end
  end

  // driver: inputs move on the falling edge only, one assignment per signal
  always @(negedge clk) begin
    image_byte_t nxt;
    if (rst) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
      if (!push || item_taken) begin
        item_taken = 1'b0;
        if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_bytes.pop_front();
          data_byte <= nxt.data;
          restart   <= nxt.restart;
          push      <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  task automatic queue_byte(input logic [7:0] d, input logic rs);
    pending_bytes.push_back('{d, rs});
    queued_count++;
  endtask

  // random bytes with an occasional restart in mid packet
  task automatic queue_noise(input int n);
    for (int i = 0; i < n; i++) queue_byte(8'($urandom), ($urandom_range(15) == 0));
  endtask

  // hold the sender until everything sent has come back out
  task automatic wait_for_drain();
    while (accepted_count != queued_count || expected_beats.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, header on first byte, restarts at start and mid packet
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFE, 1'b0);
    queue_byte(8'h7F, 1'b1);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hFF, 1'b1);
    wait_for_drain();

    // sender mostly busy, receiver mostly stalled
    queue_noise(70);
    wait_for_drain();

    send_idle_pct = 59;
    recv_idle_pct = 14;
    queue_noise(70);
    wait_for_drain();

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_noise(80);
    wait_for_drain();

    // let any stray beat show up before the verdict
    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
